[design/aopi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aopi_pkg - shared constants for the arc odometry pose integrator
// fixed-point constants, serial unit sizes and the cordic arctangent table
// ----------------------------------------------------------------------------
package aopi_pkg;

  // heading units: 1/256 degree
  localparam int FULL_TURN      = 92160;
  localparam int HALF_TURN      = 46080;
  localparam int STRAIGHT_LIMIT = 64;

  // heading to binary angle: h * 2^32 / 92160 = (h << 21) / 45
  localparam int BAM_SHIFT = 21;
  localparam int BAM_DIV   = 45;

  localparam int RAD_TO_HU_Q8    = 3754936;
  localparam int CORDIC_GAIN_Q30 = 652032874;
  localparam int IPD_RESET       = 134209;

  // serial multiplier: 64-bit multiplicand, 34-bit signed multiplier
  localparam int MUL_BITS  = 34;
  localparam int MUL_CNT_W = 6;

  // serial divider: 64-bit dividend, 16-bit divisor
  localparam int DIV_BITS  = 64;
  localparam int DIV_CNT_W = 7;
  localparam int DEN_W     = 16;

  // cordic rotations, at most 24
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_CNT_W = 5;
  localparam int CW           = 34;

  function automatic logic signed [CW-1:0] atan_bam(input logic [CORDIC_CNT_W-1:0] i);
    logic signed [CW-1:0] r;
    case (i)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[design/arc_odometry_pose_integrator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_odometry_pose_integrator - differential drive arc odometry
// integrates encoder and gyro updates into a saturating Q16.16 pose
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_stall_o) carries one request per
//   transaction: update pose, reset odometry or reset relative distances
//   output channel (out_valid_o / out_stall_i) returns one transaction per
//   request with the pose and relative wheel distances after that request
//   cfg channel (cfg_valid_i / cfg_ready_o) writes inches_per_degree; write
//   it only while the block is idle
//   one request is worked on at a time; in_stall_o stays high until its
//   result sits in the output register
//   reset requests finish quickest, a straight update is shorter than an
//   arc update; the time is set by the bit-serial multiplier, restoring
//   divider and 16-step cordic, which the sequencer uses one after
//   another
//   a stalled receiver holds the result; the next request is still taken
//   and its result waits for the output register to drain
//   reset clears the pose, the last readings and the relative distances,
//   and loads the default inches_per_degree
// ----------------------------------------------------------------------------
module arc_odometry_pose_integrator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] left_angle_i,
  input  logic signed [31:0] right_angle_i,
  input  logic [16:0]        heading_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] rel_left_o,
  output logic signed [31:0] rel_right_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [23:0]        cfg_data_i
);

  // request kinds
  localparam logic [1:0] REQ_UPDATE    = 2'd0;
  localparam logic [1:0] REQ_RESET_ODO = 2'd1;
  localparam logic [1:0] REQ_RESET_REL = 2'd2;

  // sequencer states
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_ML   = 5'd1;   // left travel
  localparam logic [4:0] ST_MR   = 5'd2;   // right travel
  localparam logic [4:0] ST_PREP = 5'd3;   // starts the heading-to-angle division of the last heading
  localparam logic [4:0] ST_BAM0 = 5'd4;
  localparam logic [4:0] ST_COR0 = 5'd5;
  localparam logic [4:0] ST_BAM1 = 5'd6;
  localparam logic [4:0] ST_COR1 = 5'd7;
  localparam logic [4:0] ST_MC   = 5'd8;
  localparam logic [4:0] ST_DC   = 5'd9;
  localparam logic [4:0] ST_KC   = 5'd10;
  localparam logic [4:0] ST_MS   = 5'd11;
  localparam logic [4:0] ST_DS   = 5'd12;
  localparam logic [4:0] ST_KS   = 5'd13;
  localparam logic [4:0] ST_SX   = 5'd14;
  localparam logic [4:0] ST_SY   = 5'd15;
  localparam logic [4:0] ST_ACC  = 5'd16;
  localparam logic [4:0] ST_FIN  = 5'd17;

  localparam int CW = aopi_pkg::CW;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fff_ffff;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // product rounded half up to Q16.16
  function automatic logic signed [31:0] to_inch(input logic [63:0] p);
    logic signed [63:0] s;
    s = $signed(p) + 64'sd128;
    return sat32(s >>> 8);
  endfunction

  logic [4:0]  state_q;
  logic        go_q;
  logic [1:0]  req_q;

  // persistent state
  logic signed [31:0] x_acc_q, y_acc_q, last_l_q, last_r_q, zl_q, zr_q;
  logic [16:0]        last_h_q;
  logic [23:0]        ipd_q;

  // per-request working registers
  logic signed [31:0]   la_q, ra_q, al_q;
  logic [16:0]          h_q;
  logic signed [32:0]   dist_q;
  logic signed [17:0]   dh_q;
  logic signed [CW-1:0] c0_q, s0_q, c1_q, s1_q;
  logic [63:0]          t_q;
  logic                 qneg_q;
  logic signed [36:0]   ax_q, ay_q;

  // output register
  logic               out_valid_q;
  logic signed [31:0] pos_x_q, pos_y_q, rel_l_q, rel_r_q;

  // shared units
  logic                                mul_start, mul_done;
  logic [63:0]                         mul_a, mul_p;
  logic [aopi_pkg::MUL_BITS-1:0]       mul_b;
  logic                                div_start, div_done;
  logic [aopi_pkg::DIV_BITS-1:0]       div_num, div_quot;
  logic [aopi_pkg::DEN_W-1:0]          div_den;
  logic                                cor_start, cor_done;
  logic signed [CW-1:0]                cor_cos, cor_sin;

  logic                 in_acc;
  logic [16:0]          h_in;
  logic signed [31:0]   ar_new;
  logic signed [32:0]   dl, dr;
  logic signed [33:0]   dsum;
  logic signed [17:0]   dh_raw, dh_wrap;
  logic [aopi_pkg::DEN_W-1:0] dh_abs;
  logic                 straight;
  logic signed [CW:0]   dcos, dsin;
  logic [63:0]          t_abs;
  logic [63:0]          qs;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // heading reduced into one turn
  assign h_in = (heading_i >= 17'(aopi_pkg::FULL_TURN)) ?
                heading_i - 17'(aopi_pkg::FULL_TURN) : heading_i;

  // right travel straight off the multiplier
  assign ar_new = to_inch(mul_p);

  assign dl   = {al_q[31], al_q} - {last_l_q[31], last_l_q};
  assign dr   = {ar_new[31], ar_new} - {last_r_q[31], last_r_q};

  // heading change wrapped to plus or minus half a turn
  always_comb begin
    dh_raw  = $signed({1'b0, h_q}) - $signed({1'b0, last_h_q});
    dh_wrap = dh_raw;
    if (dh_raw > 18'(aopi_pkg::HALF_TURN)) begin
      dh_wrap = dh_raw - 18'(aopi_pkg::FULL_TURN);
    end else if (dh_raw < -18'sd46080) begin
      dh_wrap = dh_raw + 18'(aopi_pkg::FULL_TURN);
    end
  end

  assign dh_abs   = dh_q[17] ? 16'(-dh_q) : dh_q[15:0];
  assign straight = (dh_abs < 16'(aopi_pkg::STRAIGHT_LIMIT));
  assign dcos     = {c1_q[CW-1], c1_q} - {c0_q[CW-1], c0_q};
  assign dsin     = {s1_q[CW-1], s1_q} - {s0_q[CW-1], s0_q};
  assign t_abs    = t_q[63] ? -t_q : t_q;
  assign qs       = {{8{t_q[63]}}, t_q[63:8]};

  // unit starts
  assign mul_start = go_q && (state_q inside {ST_ML, ST_MR, ST_MC, ST_KC, ST_MS, ST_KS,
                                              ST_SX, ST_SY});
  assign div_start = go_q && (state_q inside {ST_BAM0, ST_BAM1, ST_DC, ST_DS});
  assign cor_start = go_q && (state_q inside {ST_COR0, ST_COR1});

  // operand selection
  always_comb begin
    mul_a   = '0;
    mul_b   = {dist_q[32], dist_q};
    div_num = t_abs;
    div_den = dh_abs;
    case (state_q)
      ST_ML: begin
        mul_a = {{32{la_q[31]}}, la_q};
        mul_b = {10'b0, ipd_q};
      end
      ST_MR: begin
        mul_a = {{32{ra_q[31]}}, ra_q};
        mul_b = {10'b0, ipd_q};
      end
      ST_MC: mul_a = {{31{dcos[CW]}}, dcos[CW:2]};
      ST_MS: mul_a = {{31{dsin[CW]}}, dsin[CW:2]};
      ST_KC, ST_KS: begin
        mul_a = qs;
        mul_b = aopi_pkg::MUL_BITS'(aopi_pkg::RAD_TO_HU_Q8);
      end
      ST_SX: mul_a = {{32{s0_q[CW-1]}}, s0_q[CW-1:2]};
      ST_SY: mul_a = {{32{c0_q[CW-1]}}, c0_q[CW-1:2]};
      ST_BAM0: begin
        div_num = 64'(last_h_q) << aopi_pkg::BAM_SHIFT;
        div_den = 16'(aopi_pkg::BAM_DIV);
      end
      ST_BAM1: begin
        div_num = 64'(h_q) << aopi_pkg::BAM_SHIFT;
        div_den = 16'(aopi_pkg::BAM_DIV);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  aopi_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  aopi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  aopi_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .bam_i   (t_q[31:0]),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  assign dsum = {dl[32], dl} + {dr[32], dr};

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ipd_q <= 24'(aopi_pkg::IPD_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      ipd_q <= cfg_data_i;
    end
  end

  // sequencer and persistent state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      go_q        <= 1'b0;
      req_q       <= REQ_UPDATE;
      x_acc_q     <= '0;
      y_acc_q     <= '0;
      last_l_q    <= '0;
      last_r_q    <= '0;
      last_h_q    <= '0;
      zl_q        <= '0;
      zr_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      go_q <= 1'b0;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            req_q <= req_type_i;
            case (req_type_i)
              REQ_UPDATE: begin
                state_q <= ST_ML;
                go_q    <= 1'b1;
              end
              REQ_RESET_ODO: begin
                x_acc_q  <= '0;
                y_acc_q  <= '0;
                last_l_q <= '0;
                last_r_q <= '0;
                last_h_q <= '0;
                zl_q     <= '0;
                zr_q     <= '0;
                state_q  <= ST_FIN;
              end
              REQ_RESET_REL: begin
                zl_q    <= '0;
                zr_q    <= '0;
                state_q <= ST_FIN;
              end
              default: state_q <= ST_FIN;
            endcase
          end
        end
        ST_ML: begin
          if (mul_done) begin
            state_q <= ST_MR;
            go_q    <= 1'b1;
          end
        end
        ST_MR: begin
          // right travel lands straight into the delta math
          if (mul_done) begin
            zl_q     <= sat32({{32{zl_q[31]}}, zl_q} + {{31{dl[32]}}, dl});
            zr_q     <= sat32({{32{zr_q[31]}}, zr_q} + {{31{dr[32]}}, dr});
            last_l_q <= al_q;
            last_r_q <= ar_new;
            state_q  <= ST_PREP;
          end
        end
        ST_PREP: begin
          state_q <= ST_BAM0;
          go_q    <= 1'b1;
        end
        ST_BAM0: begin
          if (div_done) begin
            state_q <= ST_COR0;
            go_q    <= 1'b1;
          end
        end
        ST_COR0: begin
          if (cor_done) begin
            // a turn under a quarter degree counts as straight travel
            state_q <= straight ? ST_SX : ST_BAM1;
            go_q    <= 1'b1;
          end
        end
        ST_BAM1: begin
          if (div_done) begin
            state_q <= ST_COR1;
            go_q    <= 1'b1;
          end
        end
        ST_COR1: begin
          if (cor_done) begin
            state_q <= ST_MC;
            go_q    <= 1'b1;
          end
        end
        ST_MC: begin
          if (mul_done) begin
            state_q <= ST_DC;
            go_q    <= 1'b1;
          end
        end
        ST_DC: begin
          if (div_done) begin
            state_q <= ST_KC;
            go_q    <= 1'b1;
          end
        end
        ST_KC: begin
          if (mul_done) begin
            state_q <= ST_MS;
            go_q    <= 1'b1;
          end
        end
        ST_MS: begin
          if (mul_done) begin
            state_q <= ST_DS;
            go_q    <= 1'b1;
          end
        end
        ST_DS: begin
          if (div_done) begin
            state_q <= ST_KS;
            go_q    <= 1'b1;
          end
        end
        ST_KS: begin
          if (mul_done) state_q <= ST_ACC;
        end
        ST_SX: begin
          if (mul_done) begin
            state_q <= ST_SY;
            go_q    <= 1'b1;
          end
        end
        ST_SY: begin
          if (mul_done) state_q <= ST_ACC;
        end
        ST_ACC: begin
          x_acc_q  <= sat32({{32{x_acc_q[31]}}, x_acc_q} + {{27{ax_q[36]}}, ax_q});
          y_acc_q  <= sat32({{32{y_acc_q[31]}}, y_acc_q} + {{27{ay_q[36]}}, ay_q});
          last_h_q <= h_q;
          state_q  <= ST_FIN;
        end
        ST_FIN: begin
          // wait for the output register to drain
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      la_q <= left_angle_i;
      ra_q <= right_angle_i;
      h_q  <= h_in;
    end
    case (state_q)
      ST_ML: if (mul_done) al_q <= to_inch(mul_p);
      ST_MR: if (mul_done) begin
        dist_q <= dsum[33:1];
        dh_q   <= dh_wrap;
      end
      ST_BAM0, ST_BAM1: if (div_done) t_q <= div_quot;
      ST_COR0: if (cor_done) begin
        c0_q <= cor_cos;
        s0_q <= cor_sin;
      end
      ST_COR1: if (cor_done) begin
        c1_q <= cor_cos;
        s1_q <= cor_sin;
      end
      ST_MC, ST_MS: if (mul_done) begin
        t_q    <= mul_p;
        qneg_q <= mul_p[63] ^ dh_q[17];
      end
      ST_DC, ST_DS: if (div_done) t_q <= qneg_q ? -div_quot : div_quot;
      ST_KC: if (mul_done) ax_q <= -{mul_p[63], mul_p[63:28]};
      ST_KS: if (mul_done) ay_q <= {mul_p[63], mul_p[63:28]};
      ST_SX: if (mul_done) ax_q <= {mul_p[63], mul_p[63:28]};
      ST_SY: if (mul_done) ay_q <= {mul_p[63], mul_p[63:28]};
      ST_FIN: if (!out_valid_q || !out_stall_i) begin
        pos_x_q <= x_acc_q;
        pos_y_q <= y_acc_q;
        rel_l_q <= zl_q;
        rel_r_q <= zr_q;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign rel_left_o  = rel_l_q;
  assign rel_right_o = rel_r_q;

endmodule

[design/aopi_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aopi_mul - bit-serial shift-add multiplier
// one multiplier bit per cycle, product kept modulo 2^64
// ----------------------------------------------------------------------------
module aopi_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [63:0]                       a_i,
  input  logic [aopi_pkg::MUL_BITS-1:0]     b_i,
  output logic                              done_o,
  output logic [63:0]                       p_o
);

  logic                           busy_q, done_q;
  logic [aopi_pkg::MUL_CNT_W-1:0] cnt_q;
  logic [63:0]                    acc_q, a_q;
  logic [aopi_pkg::MUL_BITS-1:0]  b_q;
  logic                           last;

  assign last = (cnt_q == aopi_pkg::MUL_CNT_W'(aopi_pkg::MUL_BITS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
    end else if (busy_q) begin
      // sign bit of the multiplier carries negative weight
      if (b_q[0]) acc_q <= last ? acc_q - a_q : acc_q + a_q;
      a_q <= {a_q[62:0], 1'b0};
      b_q <= {1'b0, b_q[aopi_pkg::MUL_BITS-1:1]};
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

[design/aopi_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aopi_div - radix-2 restoring divider
// unsigned 64-bit dividend by 16-bit divisor, one quotient bit per cycle
// ----------------------------------------------------------------------------
module aopi_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [aopi_pkg::DIV_BITS-1:0]  num_i,
  input  logic [aopi_pkg::DEN_W-1:0]     den_i,
  output logic                           done_o,
  output logic [aopi_pkg::DIV_BITS-1:0]  quot_o
);

  logic                           busy_q, done_q;
  logic [aopi_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [aopi_pkg::DIV_BITS-1:0]  num_q;
  logic [aopi_pkg::DEN_W-1:0]     den_q, rem_q;
  logic [aopi_pkg::DEN_W:0]       trial, diff;
  logic                           ge;

  assign trial = {rem_q, num_q[aopi_pkg::DIV_BITS-1]};
  assign ge    = (trial >= {1'b0, den_q});
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == aopi_pkg::DIV_CNT_W'(aopi_pkg::DIV_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[aopi_pkg::DEN_W-1:0] : trial[aopi_pkg::DEN_W-1:0];
      num_q <= {num_q[aopi_pkg::DIV_BITS-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

[design/aopi_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aopi_cordic - iterative rotation-mode cordic
// cosine and sine in Q4.30 of a 32-bit binary angle, one rotation per cycle
// ----------------------------------------------------------------------------
module aopi_cordic (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [31:0]                      bam_i,
  output logic                             done_o,
  output logic signed [aopi_pkg::CW-1:0]   cos_o,
  output logic signed [aopi_pkg::CW-1:0]   sin_o
);

  logic                              busy_q, done_q, neg_q;
  logic [aopi_pkg::CORDIC_CNT_W-1:0] cnt_q;
  logic signed [aopi_pkg::CW-1:0]    x_q, y_q, z_q, xs, ys, z0, at;

  assign xs = x_q >>> cnt_q;
  assign ys = y_q >>> cnt_q;
  assign at = aopi_pkg::atan_bam(cnt_q);

  // fold the angle into the right half plane
  always_comb begin
    z0 = $signed({2'b00, bam_i});
    if (bam_i[31:30] == 2'b11) begin
      z0 = $signed({2'b00, bam_i}) - 34'sh1_0000_0000;
    end else if (bam_i[31:30] != 2'b00) begin
      z0 = $signed({2'b00, bam_i}) - 34'sh0_8000_0000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == aopi_pkg::CORDIC_CNT_W'(aopi_pkg::CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= aopi_pkg::CW'(aopi_pkg::CORDIC_GAIN_Q30);
      y_q   <= '0;
      z_q   <= z0;
      neg_q <= (bam_i[31:30] == 2'b01) || (bam_i[31:30] == 2'b10);
    end else if (busy_q) begin
      if (!z_q[aopi_pkg::CW-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = neg_q ? -x_q : x_q;
  assign sin_o  = neg_q ? -y_q : y_q;

endmodule
